[src/wsfd_pkg.sv]
// wsfd_pkg: shared constants for the WebSocket frame deframer.
// Field widths, length escape codes, result kinds and tdata layout.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package wsfd_pkg;

    // Field widths
    localparam int BYTE_W      = 8;
    localparam int OPCODE_W    = 4;
    localparam int LEN_W       = 63;
    localparam int KEY_W       = 32;
    localparam int EXTCNT_W    = 4;
    localparam int KEYCNT_W    = 3;

    // Seven-bit length escape codes
    localparam logic [6:0] LEN_EXT16 = 7'd126;
    localparam logic [6:0] LEN_EXT64 = 7'd127;

    // Extended length byte counts
    localparam logic [EXTCNT_W-1:0] EXT16_BYTES = 4'd2;
    localparam logic [EXTCNT_W-1:0] EXT64_BYTES = 4'd8;

    // Masking key byte count
    localparam logic [KEYCNT_W-1:0] KEY_BYTES = 3'd4;

    // Result kinds (carried on tuser)
    localparam logic KIND_HEADER  = 1'b0;
    localparam logic KIND_PAYLOAD = 1'b1;

    // Result tdata layout, lowest bit first
    localparam int FIN_LSB    = 0;
    localparam int OPCODE_LSB = FIN_LSB + 1;
    localparam int MASKED_LSB = OPCODE_LSB + OPCODE_W;
    localparam int LEN_LSB    = MASKED_LSB + 1;
    localparam int DATA_LSB   = LEN_LSB + LEN_W;
    localparam int FIELDS_W   = DATA_LSB + BYTE_W;
    localparam int M_TDATA_W  = ((FIELDS_W + 7) / 8) * 8;

endpackage

`default_nettype wire

[src/websocket_frame_deframer_top.sv]
// websocket_frame_deframer_top: parses a received WebSocket byte stream.
// Emits one header beat per frame, then the unmasked payload beats.
// Depends on wsfd_pkg.
`timescale 1ns / 1ps
`default_nettype none

//  channel | dir | tdata                         | tuser        | tlast
//  s_      | in  | data_byte[7:0]                | -            | -
//  m_      | out | fin, opcode, is_masked,       | result_kind  | last_of_frame
//          |     | payload_length, data_byte_out |              |
//
// One input beat is taken per cycle while s_tready is high; its result, if
// any, appears in the output register in the next cycle. The parser state
// and output register are the only pipeline storage, so throughput is one
// beat per cycle; s_tready drops only while a result is held and m_tready
// is low. Reset (aresetn low, synchronous) returns the parser to the first
// header byte and empties the output register.
module websocket_frame_deframer_top (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    input  wire logic [wsfd_pkg::BYTE_W-1:0]  s_tdata,   // data_byte[7:0]
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    // fin[0], frame_opcode[4:1], is_masked[5], payload_length[68:6],
    // data_byte_out[76:69], zero fill[79:77]
    output logic [wsfd_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic                              m_tuser,   // result_kind
    output logic                              m_tlast    // last_of_frame
);
    import wsfd_pkg::*;

    typedef enum logic [2:0] {
        PH_HDR0,
        PH_HDR1,
        PH_EXTLEN,
        PH_MASK,
        PH_PAYLOAD
    } phase_t;

    // Parser state
    phase_t                phase_reg, phase_next;
    logic [EXTCNT_W-1:0]   ext_cnt_reg, ext_cnt_next;
    logic [LEN_W-1:0]      len_reg, len_next;
    logic [KEY_W-1:0]      key_reg, key_next;
    logic                  mask_en_reg, mask_en_next;
    logic [KEYCNT_W-1:0]   key_cnt_reg, key_cnt_next;
    logic [LEN_W-1:0]      remain_reg, remain_next;
    logic [1:0]            key_idx_reg, key_idx_next;
    logic [OPCODE_W-1:0]   opcode_reg, opcode_next;
    logic                  fin_reg, fin_next;

    // Output register
    logic                  m_valid_reg, m_valid_next;
    logic                  m_kind_reg, m_kind_next;
    logic                  m_last_reg, m_last_next;
    logic                  m_fin_reg, m_fin_next;
    logic [OPCODE_W-1:0]   m_opcode_reg, m_opcode_next;
    logic                  m_masked_reg, m_masked_next;
    logic [LEN_W-1:0]      m_len_reg, m_len_next;
    logic [BYTE_W-1:0]     m_data_reg, m_data_next;

    // Combinational step results
    logic                  s_accept;
    logic                  res_valid;
    logic                  res_kind;
    logic                  res_last;
    logic [BYTE_W-1:0]     res_data;
    logic [LEN_W-1:0]      res_len;
    logic                  res_masked;
    logic [6:0]            len7;
    logic [BYTE_W-1:0]     key_byte;
    logic                  hdr_done;

    assign s_tready = !m_valid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;
    assign len7     = s_tdata[6:0];

    // Masking key byte i, counted from the most significant byte
    always_comb begin
        case (key_idx_reg)
            2'd0:    key_byte = key_reg[31:24];
            2'd1:    key_byte = key_reg[23:16];
            2'd2:    key_byte = key_reg[15:8];
            default: key_byte = key_reg[7:0];
        endcase
    end

    // Parser next state and result
    always_comb begin
        phase_next   = phase_reg;
        ext_cnt_next = ext_cnt_reg;
        len_next     = len_reg;
        key_next     = key_reg;
        mask_en_next = mask_en_reg;
        key_cnt_next = key_cnt_reg;
        remain_next  = remain_reg;
        key_idx_next = key_idx_reg;
        opcode_next  = opcode_reg;
        fin_next     = fin_reg;
        res_valid    = 1'b0;
        res_kind     = KIND_HEADER;
        res_last     = 1'b0;
        res_data     = '0;
        res_len      = len_reg;
        res_masked   = mask_en_reg;
        hdr_done     = 1'b0;

        unique case (phase_reg)
            PH_HDR1: begin
                mask_en_next = s_tdata[7];
                res_masked   = s_tdata[7];
                if (len7 == LEN_EXT16) begin
                    len_next     = '0;
                    ext_cnt_next = EXT16_BYTES;
                    phase_next   = PH_EXTLEN;
                end else if (len7 == LEN_EXT64) begin
                    len_next     = '0;
                    ext_cnt_next = EXT64_BYTES;
                    phase_next   = PH_EXTLEN;
                end else begin
                    len_next = {{(LEN_W-7){1'b0}}, len7};
                    if (s_tdata[7]) begin
                        key_cnt_next = '0;
                        key_next     = '0;
                        phase_next   = PH_MASK;
                    end else begin
                        hdr_done = 1'b1;
                    end
                end
            end
            PH_EXTLEN: begin
                // Shifting into 63 bits drops the top bit of a 64-bit length
                len_next     = {len_reg[LEN_W-BYTE_W-1:0], s_tdata};
                ext_cnt_next = ext_cnt_reg - 1'b1;
                if (ext_cnt_reg == 4'd1) begin
                    if (mask_en_reg) begin
                        key_cnt_next = '0;
                        key_next     = '0;
                        phase_next   = PH_MASK;
                    end else begin
                        hdr_done = 1'b1;
                    end
                end
            end
            PH_MASK: begin
                key_next     = {key_reg[KEY_W-BYTE_W-1:0], s_tdata};
                key_cnt_next = key_cnt_reg + 1'b1;
                if (key_cnt_next == KEY_BYTES) begin
                    key_cnt_next = '0;
                    hdr_done     = 1'b1;
                end
            end
            PH_PAYLOAD: begin
                res_valid    = 1'b1;
                res_kind     = KIND_PAYLOAD;
                res_data     = mask_en_reg ? (s_tdata ^ key_byte) : s_tdata;
                key_idx_next = key_idx_reg + 1'b1;
                remain_next  = remain_reg - 1'b1;
                res_last     = (remain_reg == {{(LEN_W-1){1'b0}}, 1'b1});
                if (res_last) begin
                    phase_next = PH_HDR0;
                end
            end
            default: begin
                fin_next    = s_tdata[7];
                opcode_next = s_tdata[OPCODE_W-1:0];
                phase_next  = PH_HDR1;
            end
        endcase

        // Header complete: emit header beat, start payload or next frame
        if (hdr_done) begin
            res_valid = 1'b1;
            res_kind  = KIND_HEADER;
            res_len   = len_next;
            if (len_next == '0) begin
                res_last   = 1'b1;
                phase_next = PH_HDR0;
            end else begin
                remain_next  = len_next;
                key_idx_next = '0;
                phase_next   = PH_PAYLOAD;
            end
        end
    end

    // Output register load
    always_comb begin
        m_valid_next  = m_valid_reg;
        m_kind_next   = m_kind_reg;
        m_last_next   = m_last_reg;
        m_fin_next    = m_fin_reg;
        m_opcode_next = m_opcode_reg;
        m_masked_next = m_masked_reg;
        m_len_next    = m_len_reg;
        m_data_next   = m_data_reg;
        if (s_accept) begin
            m_valid_next  = res_valid;
            m_kind_next   = res_kind;
            m_last_next   = res_last;
            m_fin_next    = fin_reg;
            m_opcode_next = opcode_reg;
            m_masked_next = res_masked;
            m_len_next    = res_len;
            m_data_next   = res_data;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_HDR0;
            ext_cnt_reg <= '0;
            len_reg     <= '0;
            key_reg     <= '0;
            mask_en_reg <= 1'b0;
            key_cnt_reg <= '0;
            remain_reg  <= '0;
            key_idx_reg <= '0;
            opcode_reg  <= '0;
            fin_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (s_accept) begin
                phase_reg   <= phase_next;
                ext_cnt_reg <= ext_cnt_next;
                len_reg     <= len_next;
                key_reg     <= key_next;
                mask_en_reg <= mask_en_next;
                key_cnt_reg <= key_cnt_next;
                remain_reg  <= remain_next;
                key_idx_reg <= key_idx_next;
                opcode_reg  <= opcode_next;
                fin_reg     <= fin_next;
            end
            m_valid_reg <= m_valid_next;
        end
        // Payload fields, no reset
        m_kind_reg   <= m_kind_next;
        m_last_reg   <= m_last_next;
        m_fin_reg    <= m_fin_next;
        m_opcode_reg <= m_opcode_next;
        m_masked_reg <= m_masked_next;
        m_len_reg    <= m_len_next;
        m_data_reg   <= m_data_next;
    end

    // Result channel
    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {{(M_TDATA_W-FIELDS_W){1'b0}}, m_data_reg, m_len_reg,
                       m_masked_reg, m_opcode_reg, m_fin_reg};

endmodule

`default_nettype wire
